// ===== rtl/pdit_pkg.sv =====
// shared types and constants for the per-origin distinct-id throttle
package pdit_pkg;

  localparam logic [1:0] REG_SELF_ID = 2'd0;
  localparam logic [1:0] REG_WINDOW_MS = 2'd1;
  localparam logic [1:0] REG_MAX_PER_WINDOW = 2'd2;

  localparam logic [1:0] VERDICT_SELF = 2'd0;
  localparam logic [1:0] VERDICT_DUP = 2'd1;
  localparam logic [1:0] VERDICT_NEW = 2'd2;
  localparam logic [1:0] VERDICT_THROTTLED = 2'd3;

  localparam int RECIP_SHIFT = 16;

  typedef struct packed {
    logic [7:0]  origin;
    logic [31:0] message_id;
    logic [47:0] now_ms;
  } item_t;

  typedef struct packed {
    logic       admit;
    logic [1:0] verdict;
    logic [4:0] live_count;
  } result_t;

  typedef struct packed {
    logic [7:0]  self_id;
    logic [31:0] window_len;
    logic [4:0]  max_per_window;
  } cfg_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_QUOT = 7'b0000010,
    S_ROW  = 7'b0000100,
    S_BASE = 7'b0001000,
    S_CNT  = 7'b0010000,
    S_SCAN = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

endpackage

// ===== rtl/pdit_ram.sv =====
// generic single-write, single-read ram with registered read
module pdit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pdit_engine.sv =====
// per-origin row scan, compaction and admission sequencer over the event memories
module pdit_engine #(
  parameter int ORIGINS = 256,
  parameter int EVENTS_PER_ORIGIN = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pdit_pkg::item_t  item,
  input  pdit_pkg::cfg_t   cfg,
  output logic             done,
  output pdit_pkg::result_t result
);

  localparam int ROW_W = $clog2(ORIGINS);
  localparam int DEPTH = ORIGINS * EVENTS_PER_ORIGIN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KEPT_W = $clog2(EVENTS_PER_ORIGIN + 1);
  localparam int RECIP = (1 << pdit_pkg::RECIP_SHIFT) / ORIGINS;

  pdit_pkg::state_t state;
  logic [7:0]          origin;
  logic [31:0]         mid;
  logic [47:0]         now;
  logic [7:0]          quot;
  logic [ROW_W-1:0]    row;
  logic [ADDR_W-1:0]   base;
  logic [47:0]         cutoff;
  logic [KEPT_W-1:0]   n;
  logic [KEPT_W-1:0]   idx;
  logic [KEPT_W-1:0]   kept;
  logic                dup;
  logic [ORIGINS-1:0]  row_valid;

  logic [24:0]         prod;
  logic [15:0]         qd;
  logic [15:0]         rem;
  logic [15:0]         rem_fix;
  logic [ADDR_W-1:0]   base_c;
  logic [47:0]         cutoff_c;
  logic [KEPT_W-1:0]   cnt_rd;
  logic [KEPT_W-1:0]   cnt_c;
  logic [KEPT_W-1:0]   cap;
  logic [79:0]         ent_rd;
  logic [31:0]         ent_id;
  logic [47:0]         ent_time;
  logic                keep;
  logic                match;
  logic                ent_we;
  logic [ADDR_W-1:0]   ent_waddr;
  logic [79:0]         ent_wdata;
  logic [ADDR_W-1:0]   ent_raddr;
  logic                cnt_we;
  logic                new_ok;
  logic [KEPT_W-1:0]   kept_fin;

  assign prod = 25'(origin) * 25'(RECIP);
  assign qd = 16'(quot) * 16'(ORIGINS);
  assign rem = 16'(origin) - qd;
  assign rem_fix = (rem >= 16'(ORIGINS)) ? rem - 16'(ORIGINS) : rem;
  assign base_c = ADDR_W'(ADDR_W'(row) * ADDR_W'(EVENTS_PER_ORIGIN));
  assign cutoff_c = (now >= 48'(cfg.window_len)) ? now - 48'(cfg.window_len) : 48'd0;
  assign cnt_c = row_valid[row] ? cnt_rd : '0;
  assign cap = (6'(cfg.max_per_window) > 6'(EVENTS_PER_ORIGIN)) ?
               KEPT_W'(EVENTS_PER_ORIGIN) : KEPT_W'(cfg.max_per_window);
  assign ent_id = ent_rd[79:48];
  assign ent_time = ent_rd[47:0];
  assign keep = !(ent_time < cutoff);
  assign match = ent_id == mid;
  assign new_ok = !dup && (kept < cap);
  assign kept_fin = new_ok ? kept + 1'b1 : kept;
  assign busy = state != pdit_pkg::S_IDLE;

  always_comb begin
    ent_we = 1'b0;
    ent_waddr = base + ADDR_W'(kept);
    ent_wdata = {ent_id, match ? now : ent_time};
    ent_raddr = base;
    cnt_we = 1'b0;
    case (state)
      pdit_pkg::S_SCAN: begin
        ent_we = keep;
        ent_raddr = base + ADDR_W'(idx) + 1'b1;
      end
      pdit_pkg::S_FIN: begin
        ent_we = new_ok;
        ent_wdata = {mid, now};
        cnt_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pdit_ram #(.WIDTH(80), .DEPTH(DEPTH)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  pdit_ram #(.WIDTH(KEPT_W), .DEPTH(ORIGINS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (row),
    .wdata (kept_fin),
    .raddr (row),
    .rdata (cnt_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdit_pkg::S_IDLE;
      row_valid <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        pdit_pkg::S_IDLE: begin
          if (start) begin
            if (item.origin == cfg.self_id) begin
              done <= 1'b1;
              result <= '{admit: 1'b1, verdict: pdit_pkg::VERDICT_SELF, live_count: 5'd0};
            end else begin
              origin <= item.origin;
              mid <= item.message_id;
              now <= item.now_ms;
              state <= pdit_pkg::S_QUOT;
            end
          end
        end
        pdit_pkg::S_QUOT: begin
          quot <= prod[pdit_pkg::RECIP_SHIFT +: 8];
          state <= pdit_pkg::S_ROW;
        end
        pdit_pkg::S_ROW: begin
          row <= ROW_W'(rem_fix);
          state <= pdit_pkg::S_BASE;
        end
        pdit_pkg::S_BASE: begin
          base <= base_c;
          cutoff <= cutoff_c;
          state <= pdit_pkg::S_CNT;
        end
        pdit_pkg::S_CNT: begin
          n <= (cnt_c > KEPT_W'(EVENTS_PER_ORIGIN)) ? KEPT_W'(EVENTS_PER_ORIGIN) : cnt_c;
          idx <= '0;
          kept <= '0;
          dup <= 1'b0;
          state <= (cnt_c == '0) ? pdit_pkg::S_FIN : pdit_pkg::S_SCAN;
        end
        pdit_pkg::S_SCAN: begin
          if (keep) begin
            kept <= kept + 1'b1;
            dup <= dup | match;
          end
          idx <= idx + 1'b1;
          if (idx + 1'b1 == n) begin
            state <= pdit_pkg::S_FIN;
          end
        end
        pdit_pkg::S_FIN: begin
          row_valid[row] <= 1'b1;
          done <= 1'b1;
          result.admit <= dup || new_ok;
          result.verdict <= dup ? pdit_pkg::VERDICT_DUP :
                            (new_ok ? pdit_pkg::VERDICT_NEW : pdit_pkg::VERDICT_THROTTLED);
          result.live_count <= 5'(kept_fin);
          state <= pdit_pkg::S_IDLE;
        end
        default: begin
          state <= pdit_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/per_origin_distinct_id_throttle_core.sv =====
// Per-origin distinct-id throttle. A transaction is taken when start is high and
// busy is low; its result appears on result for one cycle with done high and cannot
// be held off. A message from self_id is answered from idle and busy stays low. Any
// other origin steps through S_QUOT, S_ROW, S_BASE and S_CNT, then scans the stored
// entries of its row (at most EVENTS_PER_ORIGIN) one entry per cycle in S_SCAN, and
// ends in S_FIN. Event counts need no clearing pass after reset.
module per_origin_distinct_id_throttle_core #(
  parameter int ORIGINS = 256,
  parameter int EVENTS_PER_ORIGIN = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pdit_pkg::item_t   item,
  output logic              done,
  output pdit_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  pdit_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_id <= 8'd0;
      cfg.window_len <= 32'd60000;
      cfg.max_per_window <= 5'd20;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdit_pkg::REG_SELF_ID: cfg.self_id <= cfg_data[7:0];
        pdit_pkg::REG_WINDOW_MS: cfg.window_len <= cfg_data;
        pdit_pkg::REG_MAX_PER_WINDOW: cfg.max_per_window <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  pdit_engine #(
    .ORIGINS(ORIGINS),
    .EVENTS_PER_ORIGIN(EVENTS_PER_ORIGIN)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

endmodule

// ===== test/per_origin_distinct_id_throttle_checker.sv =====
// checker for the distinct-id throttle: predicts verdicts and compares results
`timescale 1ns / 1ps
module per_origin_distinct_id_throttle_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pdit_pkg::item_t   item,
  input  logic              done,
  input  pdit_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                pending,
  output int                handshakes
);

  localparam int ROWS = 256;
  localparam int DEPTH = 20;

  logic [7:0]  own_id;
  logic [31:0] window;
  logic [4:0]  cap_reg;
  logic [4:0]  row_count [ROWS];
  logic [31:0] row_ids [ROWS][DEPTH];
  logic [47:0] row_times [ROWS][DEPTH];
  pdit_pkg::result_t verdict_q [$];

  function automatic pdit_pkg::result_t admit_message(pdit_pkg::item_t it);
    pdit_pkg::result_t r;
    int row;
    int kept;
    int cap;
    logic dup;
    logic [47:0] cutoff;
    r = '0;
    dup = 1'b0;
    if (it.origin == own_id) begin
      r.admit = 1'b1;
      r.verdict = pdit_pkg::VERDICT_SELF;
      return r;
    end
    row = it.origin % ROWS;
    cutoff = (it.now_ms >= {16'd0, window}) ? it.now_ms - {16'd0, window} : 48'd0;
    kept = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i < row_count[row] && row_times[row][i] >= cutoff) begin
        row_ids[row][kept] = row_ids[row][i];
        row_times[row][kept] = row_times[row][i];
        if (row_ids[row][i] == it.message_id) begin
          row_times[row][kept] = it.now_ms;
          dup = 1'b1;
        end
        kept++;
      end
    end
    cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    if (dup) begin
      r.admit = 1'b1;
      r.verdict = pdit_pkg::VERDICT_DUP;
    end else if (kept >= cap) begin
      r.admit = 1'b0;
      r.verdict = pdit_pkg::VERDICT_THROTTLED;
    end else begin
      row_ids[row][kept] = it.message_id;
      row_times[row][kept] = it.now_ms;
      kept++;
      r.admit = 1'b1;
      r.verdict = pdit_pkg::VERDICT_NEW;
    end
    row_count[row] = kept[4:0];
    r.live_count = kept[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pdit_pkg::result_t want;
    int err_inc;
    int hs_inc;
    err_inc = 0;
    hs_inc = 0;
    if (rst) begin
      own_id <= 8'd0;
      window <= 32'd60000;
      cap_reg <= 5'd20;
      for (int i = 0; i < ROWS; i++) row_count[i] = '0;
      verdict_q.delete();
      errors <= 0;
      handshakes <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        hs_inc = hs_inc + 1;
        if (verdict_q.size() == 0) begin
          $error("result with no transaction outstanding");
          err_inc = err_inc + 1;
        end else begin
          want = verdict_q.pop_front();
          if (result.admit !== want.admit) begin
            $error("admit expected %0d got %0d", want.admit, result.admit);
            err_inc = err_inc + 1;
          end
          if (result.verdict !== want.verdict) begin
            $error("verdict expected %0d got %0d", want.verdict, result.verdict);
            err_inc = err_inc + 1;
          end
          if (result.live_count !== want.live_count) begin
            $error("live_count expected %0d got %0d", want.live_count, result.live_count);
            err_inc = err_inc + 1;
          end
        end
      end
      if (start && !busy) begin
        hs_inc = hs_inc + 1;
        verdict_q.push_back(admit_message(item));
      end
      if (cfg_valid && cfg_ready) begin
        hs_inc = hs_inc + 1;
        case (cfg_index)
          pdit_pkg::REG_SELF_ID:        own_id <= cfg_data[7:0];
          pdit_pkg::REG_WINDOW_MS:      window <= cfg_data;
          pdit_pkg::REG_MAX_PER_WINDOW: cap_reg <= cfg_data[4:0];
          default: ;
        endcase
      end
      errors <= errors + err_inc;
      handshakes <= handshakes + hs_inc;
      pending <= verdict_q.size();
    end
  end

endmodule

// ===== test/tb_per_origin_distinct_id_throttle_core.sv =====
// testbench top for the distinct-id throttle: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_per_origin_distinct_id_throttle_core;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pdit_pkg::item_t   item = '0;
  logic        done;
  pdit_pkg::result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = pdit_pkg::REG_SELF_ID;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          handshakes;

  int          gap_pct;
  logic [7:0]  own_id;
  logic [31:0] window;
  logic [47:0] clock_ms;
  logic [7:0]  origins [4];

  per_origin_distinct_id_throttle_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  per_origin_distinct_id_throttle_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
    .pending(pending), .handshakes(handshakes)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_message(input logic [7:0] org, input logic [31:0] id,
                              input logic [47:0] t);
    logic taken;
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    item <= '{origin: org, message_id: id, now_ms: t};
    forever begin
      taken = !busy;
      @(posedge clk);
      if (taken) break;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    logic taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      taken = cfg_ready;
      @(posedge clk);
      @(negedge clk);
      if (taken) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      pdit_pkg::REG_SELF_ID:   own_id = data[7:0];
      pdit_pkg::REG_WINDOW_MS: window = data;
      default: ;
    endcase
  endtask

  task automatic random_traffic(input int count);
    logic [7:0]  org;
    logic [31:0] id;
    logic [63:0] step;
    for (int i = 0; i < 4; i++) origins[i] = $urandom_range(0, 255);
    step = (window == 0) ? 64'd3 : ({32'd0, window} >> 2) + 64'd1;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0:       org = own_id;
        1:       org = $urandom_range(0, 255);
        default: org = origins[$urandom_range(0, 3)];
      endcase
      id = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 23) : $urandom();
      if ($urandom_range(0, 3) != 0)
        clock_ms = clock_ms + 48'(64'($urandom()) % step);
      if ($urandom_range(0, 49) == 0) clock_ms = {$urandom(), 16'($urandom())};
      send_message(org, id, clock_ms);
      if (n == count / 2 && $urandom_range(0, 1) == 0) drain();
    end
  endtask

  int idle_cycles = 0;
  int last_handshakes = 0;
  always @(negedge clk) begin
    if (handshakes != last_handshakes || rst) begin
      idle_cycles <= 0;
      last_handshakes <= handshakes;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    own_id = 8'd0;
    window = 32'd60000;
    clock_ms = '0;
    gap_pct = 15;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: self bypass, duplicate, expiry at the cutoff edge, backwards time
    send_message(8'd0, 32'd0, 48'd0);
    send_message(8'd255, 32'hFFFF_FFFF, 48'd0);
    send_message(8'd255, 32'hFFFF_FFFF, 48'd10);
    send_message(8'd255, 32'd0, 48'd60010);
    send_message(8'd255, 32'd1, 48'd120011);
    send_message(8'd1, 32'd5, 48'd200000);
    send_message(8'd1, 32'd5, 48'd100000);
    send_message(8'd1, 32'd6, 48'd100001);
    send_message(8'hAA, 32'hA5A5_A5A5, 48'hAAAA_AAAA_AAAA);
    send_message(8'h55, 32'h5A5A_5A5A, 48'h5555_5555_5555);
    send_message(8'h55, 32'h5A5A_5A5B, 48'hFFFF_FFFF_FFFF);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd0);
    send_message(8'd7, 32'd1, 48'd5);
    send_message(8'd1, 32'd5, 48'd100002);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd31);
    write_reg(pdit_pkg::REG_SELF_ID, 32'd255);
    send_message(8'd255, 32'd9, 48'd0);
    send_message(8'd0, 32'd9, 48'd0);
    write_reg(pdit_pkg::REG_WINDOW_MS, 32'd0);
    send_message(8'd0, 32'd9, 48'd0);
    send_message(8'd0, 32'd10, 48'd1);

    write_reg(pdit_pkg::REG_WINDOW_MS, 32'd60000);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd20);
    random_traffic(75);
    write_reg(pdit_pkg::REG_WINDOW_MS, 32'd100);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd3);
    random_traffic(75);
    gap_pct = 55;
    write_reg(pdit_pkg::REG_SELF_ID, 32'h5A);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd0);
    random_traffic(60);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd31);
    write_reg(pdit_pkg::REG_WINDOW_MS, 32'd0);
    random_traffic(75);
    gap_pct = 0;
    write_reg(pdit_pkg::REG_WINDOW_MS, 32'hFFFF_FFFF);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd20);
    random_traffic(75);
    write_reg(pdit_pkg::REG_SELF_ID, 32'd0);
    write_reg(pdit_pkg::REG_WINDOW_MS, 32'd1000);
    write_reg(pdit_pkg::REG_MAX_PER_WINDOW, 32'd5);
    random_traffic(75);

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== per_origin_distinct_id_throttle_core.f =====
rtl/pdit_pkg.sv
rtl/pdit_ram.sv
rtl/pdit_engine.sv
rtl/per_origin_distinct_id_throttle_core.sv
test/per_origin_distinct_id_throttle_checker.sv
test/tb_per_origin_distinct_id_throttle_core.sv
